// ===== hdl/btim_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// btim_pkg
// Shared constants and types of the broadcast tile index mapper.
// ----------------------------------------------------------------------------
package btim_pkg;

    localparam int MAX_DIMS_DEF   = 8;
    localparam int DIM_BITS_DEF   = 16;
    localparam int INDEX_BITS_DEF = 32;

    // each dimension size sits in a 16-bit slot of its register
    localparam int SLOT_BITS      = 16;
    localparam int SLOTS_PER_WORD = 4;

    localparam int TILE_W = 32;
    localparam int CFG_W  = 64;
    localparam int ADDR_W = 6;
    localparam int RANK_W = 4;
    localparam int MASK_W = 8;

    localparam logic [CFG_W-1:0] DIMS_RESET = 64'h0001_0001_0001_0001;

    // register index, taken from paddr[5:3]
    typedef enum logic [2:0] {
        REG_RANK     = 3'd0,
        REG_DEST_LO  = 3'd1,
        REG_DEST_HI  = 3'd2,
        REG_SRC_LO   = 3'd3,
        REG_SRC_HI   = 3'd4,
        REG_BCAST    = 3'd5
    } t_reg_idx;

endpackage : btim_pkg
`default_nettype wire

// ===== hdl/broadcast_tile_index_mapper_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// broadcast_tile_index_mapper_unit
// Maps a linear destination tile index to the source tile index of a
// broadcast tensor, through per-dimension divide, modulo and stride sums.
//
// Input channel: i_valid / o_ready carry i_tile_index, one transfer per edge
// with both high. Output channel: o_valid / i_ready carry o_source_tile.
// Configuration: APB-style write/read port, 64-bit registers at 8*i.
// Pipeline: MAX_DIMS settle stages for the stride products, INDEX_BITS
// one-bit divide stages by the destination stride, INDEX_BITS one-bit
// modulo stages by the destination size, a multiply stage and an adder
// tree. Throughput: one item per cycle while the receiver does not stall,
// set by the bit-serial divide and modulo stages being laid out one stage
// per bit.
// Reset clears all valid bits and returns the registers to rank 1, all sizes
// 1 and no broadcast dimension. When the receiver stalls, each stage holds
// its item and empty stages keep filling, so input is taken until the whole
// pipe is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module broadcast_tile_index_mapper_unit #(
    parameter int MAX_DIMS   = btim_pkg::MAX_DIMS_DEF,
    parameter int DIM_BITS   = btim_pkg::DIM_BITS_DEF,
    parameter int INDEX_BITS = btim_pkg::INDEX_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // item input
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [btim_pkg::TILE_W-1:0]   i_tile_index,
    // result output
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [btim_pkg::TILE_W-1:0]        o_source_tile,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [btim_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [btim_pkg::CFG_W-1:0]    pwdata,
    output logic [btim_pkg::CFG_W-1:0]         prdata,
    output logic                               pready
);
    import btim_pkg::*;

    localparam int IB   = INDEX_BITS;
    localparam int PRE  = MAX_DIMS;
    localparam int LV   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 0;
    localparam int P    = 1 << LV;
    localparam int SB   = PRE;
    localparam int SM   = PRE + 2 * IB;
    localparam int NST  = SM + 1 + LV;

    // configuration registers
    logic [RANK_W-1:0] r_rank;
    logic [CFG_W-1:0]  r_dest_lo, r_dest_hi, r_src_lo, r_src_hi;
    logic [MASK_W-1:0] r_bcast;
    t_reg_idx          w_reg;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_reg  = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign w_wr   = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank    <= RANK_W'(1);
            r_dest_lo <= DIMS_RESET;
            r_dest_hi <= DIMS_RESET;
            r_src_lo  <= DIMS_RESET;
            r_src_hi  <= DIMS_RESET;
            r_bcast   <= '0;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_RANK:    r_rank    <= pwdata[RANK_W-1:0];
                REG_DEST_LO: r_dest_lo <= pwdata;
                REG_DEST_HI: r_dest_hi <= pwdata;
                REG_SRC_LO:  r_src_lo  <= pwdata;
                REG_SRC_HI:  r_src_hi  <= pwdata;
                REG_BCAST:   r_bcast   <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_reg)
            REG_RANK:    prdata = CFG_W'(r_rank);
            REG_DEST_LO: prdata = r_dest_lo;
            REG_DEST_HI: prdata = r_dest_hi;
            REG_SRC_LO:  prdata = r_src_lo;
            REG_SRC_HI:  prdata = r_src_hi;
            REG_BCAST:   prdata = CFG_W'(r_bcast);
            default:     prdata = '0;
        endcase
    end

    // per-dimension sizes and running strides
    logic [DIM_BITS-1:0] w_dd [MAX_DIMS];
    logic [DIM_BITS-1:0] w_sd [MAX_DIMS];
    logic [IB-1:0]       r_ds [MAX_DIMS];
    logic [IB-1:0]       r_ss [MAX_DIMS];

    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
        localparam int SL = SLOT_BITS * (d % SLOTS_PER_WORD);
        if (d < SLOTS_PER_WORD) begin : g_lo
            assign w_dd[d] = r_dest_lo[SL +: DIM_BITS];
            assign w_sd[d] = r_src_lo[SL +: DIM_BITS];
        end else begin : g_hi
            assign w_dd[d] = r_dest_hi[SL +: DIM_BITS];
            assign w_sd[d] = r_src_hi[SL +: DIM_BITS];
        end

        // stride chain, each stride registered from the one below it, settles after a register write
        if (d == 0) begin : g_s0
            always_ff @(posedge i_clk) begin
                r_ds[d] <= IB'(1);
                r_ss[d] <= IB'(1);
            end
        end else begin : g_sn
            logic [IB+DIM_BITS-1:0] w_dp, w_sp;
            assign w_dp = r_ds[d-1] * w_dd[d-1];
            assign w_sp = r_ss[d-1] * w_sd[d-1];
            always_ff @(posedge i_clk) begin
                r_ds[d] <= w_dp[IB-1:0];
                r_ss[d] <= w_sp[IB-1:0];
            end
        end
    end

    // pipeline flow control, a stage loads when empty or draining
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || i_ready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // settle stages carrying the index
    logic [IB-1:0] r_idx [PRE];

    for (genvar k = 0; k < PRE; k++) begin : g_pre
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_idx[k] <= i_tile_index[IB-1:0];
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_idx[k] <= r_idx[k-1];
                end
            end
        end
    end

    // bit-serial divide by stride, then modulo by size, one bit per stage
    logic [IB-1:0] r_w   [2*IB][MAX_DIMS];
    logic [IB:0]   r_rem [2*IB][MAX_DIMS];

    for (genvar j = 0; j < 2 * IB; j++) begin : g_div
        for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
            logic [IB-1:0] w_pw;
            logic [IB:0]   w_pr, w_sh, w_dv;
            logic          w_ge;
            always_comb begin
                w_pw = (j == 0) ? r_idx[PRE-1] : r_w[(j == 0) ? 0 : j-1][d];
                w_pr = (j == 0 || j == IB) ? '0 : r_rem[(j == 0) ? 0 : j-1][d];
                w_dv = (j < IB) ? {1'b0, r_ds[d]} : (IB+1)'(w_dd[d]);
                w_sh = {w_pr[IB-1:0], w_pw[IB-1]};
                w_ge = (w_sh >= w_dv);
            end
            always_ff @(posedge i_clk) begin
                if (w_en[SB+j]) begin
                    r_w[j][d]   <= {w_pw[IB-2:0], w_ge};
                    r_rem[j][d] <= w_ge ? (w_sh - w_dv) : w_sh;
                end
            end
        end
    end

    // coordinate times source stride, masked dimensions give zero
    logic [IB-1:0] r_tree [LV+1][P];

    for (genvar d = 0; d < P; d++) begin : g_mul
        if (d < MAX_DIMS) begin : g_act
            logic                   w_use;
            logic [DIM_BITS-1:0]    w_crd;
            logic [IB+DIM_BITS-1:0] w_pr;
            assign w_use = (RANK_W'(d) < r_rank) && !r_bcast[d]
                           && (w_dd[d] != '0) && (r_ds[d] != '0);
            assign w_crd = w_use ? r_rem[2*IB-1][d][DIM_BITS-1:0] : '0;
            assign w_pr  = w_crd * r_ss[d];
            always_ff @(posedge i_clk) begin
                if (w_en[SM]) begin
                    r_tree[0][d] <= w_pr[IB-1:0];
                end
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_tree[0][d] <= '0;
            end
        end
    end

    // registered adder tree
    for (genvar l = 1; l <= LV; l++) begin : g_lvl
        for (genvar e = 0; e < (P >> l); e++) begin : g_node
            always_ff @(posedge i_clk) begin
                if (w_en[SM+l]) begin
                    r_tree[l][e] <= r_tree[l-1][2*e] + r_tree[l-1][2*e+1];
                end
            end
        end
        for (genvar e = (P >> l); e < P; e++) begin : g_unused
            always_ff @(posedge i_clk) begin
                r_tree[l][e] <= '0;
            end
        end
    end

    assign o_source_tile = TILE_W'(r_tree[LV][0]);

endmodule : broadcast_tile_index_mapper_unit
`default_nettype wire
